[src/cfsrch_pkg.sv]
// Shared constants for the circular FIFO with search: operation codes,
// status codes and fixed payload widths. No dependencies.
package cfsrch_pkg;

  // Payload field widths
  localparam int unsigned OpW     = 3;
  localparam int unsigned WordW   = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OffsW   = 4;
  localparam int unsigned CntW    = 5;
  localparam int unsigned CapW    = 5;

  // Operation codes
  localparam logic [OpW-1:0] OP_ENQ   = 3'd0;
  localparam logic [OpW-1:0] OP_DEQ   = 3'd1;
  localparam logic [OpW-1:0] OP_PEEK  = 3'd2;
  localparam logic [OpW-1:0] OP_FIND  = 3'd3;
  localparam logic [OpW-1:0] OP_COUNT = 3'd4;
  localparam logic [OpW-1:0] OP_CLEAR = 3'd5;

  // Status codes
  localparam logic [StatusW-1:0] ST_OK       = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL     = 2'd1;
  localparam logic [StatusW-1:0] ST_EMPTY    = 2'd2;
  localparam logic [StatusW-1:0] ST_NOTFOUND = 2'd3;

  // Reset value of the capacity register
  localparam logic [CapW-1:0] CAP_RESET = 5'd16;

endpackage

[src/cfsrch_req_if.sv]
// Request channel of the circular FIFO: valid/ready plus op and word.
// Depends on cfsrch_pkg.
interface cfsrch_req_if;
  import cfsrch_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OpW-1:0]          op;
  logic signed [WordW-1:0] data_in;

  modport source (output valid, output op, output data_in, input ready);
  modport sink   (input valid, input op, input data_in, output ready);
endinterface

[src/cfsrch_rsp_if.sv]
// Response channel of the circular FIFO: valid/ready plus result fields.
// Depends on cfsrch_pkg.
interface cfsrch_rsp_if;
  import cfsrch_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [StatusW-1:0]      status;
  logic signed [WordW-1:0] data_out;
  logic [OffsW-1:0]        found_offset;
  logic [CntW-1:0]         match_count;
  logic [CntW-1:0]         fill_level;
  logic                    is_empty;
  logic                    is_full;

  modport source (output valid, output status, output data_out, output found_offset,
                  output match_count, output fill_level, output is_empty,
                  output is_full, input ready);
  modport sink   (input valid, input status, input data_out, input found_offset,
                  input match_count, input fill_level, input is_empty,
                  input is_full, output ready);
endinterface

[src/circular_fifo_with_search_core.sv]
// Circular FIFO of signed words with find and count, one transaction at a time.
// Enqueue, clear and unused ops go straight to the response; dequeue and peek read one
// entry and find and count read fill_level entries in the ring scan (one entry per
// cycle through one shared comparator). Dequeue and peek on an empty ring skip the scan.
// Request ready only while idle, so a new request waits until the last response is loaded.
// Reset (rst, synchronous): pointers and fill count cleared, capacity 16, no
// response pending; ring storage is not cleared.
module circular_fifo_with_search_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cfsrch_pkg::CapW-1:0]   cfg_wdata,
  cfsrch_req_if.sink                    req,
  cfsrch_rsp_if.source                  rsp
);
  import cfsrch_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned TW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t                  state;
  logic [CapW-1:0]         capacity;
  logic [PW-1:0]           head;
  logic [PW-1:0]           tail;
  logic [TW-1:0]           total;

  logic [OpW-1:0]          op_q;
  logic [WordW-1:0]        word_q;
  logic [StatusW-1:0]      st_q;
  logic                    found;
  logic [PW-1:0]           offs;
  logic [TW-1:0]           cnt;
  logic [WordW-1:0]        dout;
  logic [PW-1:0]           ptr;
  logic [TW-1:0]           iss;
  logic [TW-1:0]           scan_len;
  logic                    cmp_valid;
  logic [TW-1:0]           cmp_idx;
  logic [WordW-1:0]        rd_data;

  logic [WordW-1:0]        ring [DEPTH];

  logic [TW-1:0]           eff_cap;
  logic                    accept;
  logic                    is_full_now;
  logic                    deq_ok;
  logic                    rsp_load;
  logic [TW-1:0]           total_after;
  logic [StatusW-1:0]      status_res;
  logic [WordW-1:0]        dout_res;
  logic [OffsW-1:0]        offs_res;
  logic [CntW-1:0]         cnt_res;
  logic [CntW-1:0]         fill_res;

  // Advance a ring pointer, wrapping at the effective capacity
  function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p,
                                             input logic [TW-1:0] cap);
    logic [PW:0] n;
    n = {1'b0, p} + {{PW{1'b0}}, 1'b1};
    if (32'(n) >= 32'(cap)) next_ptr = '0;
    else                    next_ptr = n[PW-1:0];
  endfunction

  // Clamp the capacity register into 1..DEPTH
  always_comb begin
    if (capacity == '0)                  eff_cap = TW'(1);
    else if (32'(capacity) > 32'(DEPTH)) eff_cap = TW'(DEPTH);
    else                                 eff_cap = TW'(capacity);
  end

  assign req.ready   = (state == S_IDLE);
  assign accept      = req.valid && req.ready;
  assign is_full_now = (32'(total) >= 32'(eff_cap));
  assign rsp_load    = (state == S_DONE) && (!rsp.valid || rsp.ready);
  assign deq_ok      = (op_q == OP_DEQ) && (st_q == ST_OK);
  assign total_after = deq_ok ? (total - TW'(1)) : total;

  // Assemble the response fields with saturation of the wide counts
  always_comb begin
    if (op_q == OP_FIND) status_res = found ? ST_OK : ST_NOTFOUND;
    else                 status_res = st_q;

    if ((op_q == OP_DEQ || op_q == OP_PEEK) && st_q == ST_OK) dout_res = dout;
    else                                                      dout_res = '0;

    if (op_q == OP_FIND && found) begin
      if (32'(offs) > 32'(15)) offs_res = 4'd15;
      else                     offs_res = OffsW'(offs);
    end else begin
      offs_res = '0;
    end

    if (op_q == OP_COUNT) begin
      if (32'(cnt) > 32'(31)) cnt_res = 5'd31;
      else                    cnt_res = CntW'(cnt);
    end else begin
      cnt_res = '0;
    end

    if (32'(total_after) > 32'(31)) fill_res = 5'd31;
    else                            fill_res = CntW'(total_after);
  end

  // Ring storage: write at tail on enqueue, registered read at scan pointer
  always_ff @(posedge clk) begin
    if (accept && req.op == OP_ENQ && !is_full_now) begin
      ring[tail] <= req.data_in;
    end
    rd_data <= ring[ptr];
  end

  // Sequencer, pointers and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      capacity  <= CAP_RESET;
      head      <= '0;
      tail      <= '0;
      total     <= '0;
      iss       <= '0;
      scan_len  <= '0;
      cmp_valid <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end

      // Drop the response once taken
      if (rsp.valid && rsp.ready && !rsp_load) begin
        rsp.valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q      <= req.op;
            word_q    <= req.data_in;
            ptr       <= head;
            iss       <= '0;
            cmp_valid <= 1'b0;
            found     <= 1'b0;
            offs      <= '0;
            cnt       <= '0;
            dout      <= '0;
            unique case (req.op)
              OP_ENQ: begin
                scan_len <= '0;
                state    <= S_DONE;
                if (is_full_now) begin
                  st_q <= ST_FULL;
                end else begin
                  st_q  <= ST_OK;
                  tail  <= next_ptr(tail, eff_cap);
                  total <= total + TW'(1);
                end
              end
              OP_DEQ, OP_PEEK: begin
                if (total == '0) begin
                  st_q     <= ST_EMPTY;
                  scan_len <= '0;
                  state    <= S_DONE;
                end else begin
                  st_q     <= ST_OK;
                  scan_len <= TW'(1);
                  state    <= S_SCAN;
                end
              end
              OP_FIND, OP_COUNT: begin
                st_q     <= ST_OK;
                scan_len <= total;
                state    <= S_SCAN;
              end
              OP_CLEAR: begin
                st_q     <= ST_OK;
                scan_len <= '0;
                state    <= S_DONE;
                head     <= '0;
                tail     <= '0;
                total    <= '0;
              end
              default: begin
                st_q     <= ST_OK;
                scan_len <= '0;
                state    <= S_DONE;
              end
            endcase
          end
        end

        S_SCAN: begin
          // Issue one read per cycle
          if (iss < scan_len) begin
            ptr       <= next_ptr(ptr, eff_cap);
            iss       <= iss + TW'(1);
            cmp_idx   <= iss;
            cmp_valid <= 1'b1;
          end else begin
            cmp_valid <= 1'b0;
          end
          // Compare the entry read last cycle
          if (cmp_valid) begin
            if (cmp_idx == '0) begin
              dout <= rd_data;
            end
            if (rd_data == word_q) begin
              cnt <= cnt + TW'(1);
              if (!found) begin
                found <= 1'b1;
                offs  <= PW'(cmp_idx);
              end
            end
          end
          if (iss == scan_len && !cmp_valid) begin
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (rsp_load) begin
            rsp.valid        <= 1'b1;
            rsp.status       <= status_res;
            rsp.data_out     <= dout_res;
            rsp.found_offset <= offs_res;
            rsp.match_count  <= cnt_res;
            rsp.fill_level   <= fill_res;
            rsp.is_empty     <= (total_after == '0);
            rsp.is_full      <= (32'(total_after) >= 32'(eff_cap));
            if (deq_ok) begin
              head  <= next_ptr(head, eff_cap);
              total <= total - TW'(1);
            end
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Fill count never exceeds the storage depth
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    32'(total) <= 32'(DEPTH))
    else $error("fill count above depth");

  // Scan never issues more reads than its length
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    iss <= scan_len)
    else $error("scan ran past its length");

  // A granted enqueue raises the fill count by one
  a_enq_count: assert property (@(posedge clk) disable iff (rst)
    (accept && req.op == OP_ENQ && !is_full_now) |=> (total == $past(total) + TW'(1)))
    else $error("enqueue did not advance fill count");

  // A refused enqueue reports a full ring
  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == ST_FULL) |-> rsp.is_full)
    else $error("full refusal without full flag");

  // Empty flag agrees with the fill level
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.is_empty == (rsp.fill_level == '0)))
    else $error("empty flag disagrees with fill level");

endmodule

[verif/cfsrch_checker.sv]
// Scoreboard for the circular FIFO with search: watches the request, response
// and capacity ports, predicts each response and compares it field by field.
// Depends on cfsrch_pkg, cfsrch_req_if and cfsrch_rsp_if.
`timescale 1ns / 100ps

module cfsrch_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [cfsrch_pkg::CapW-1:0] cfg_wdata,
  cfsrch_req_if                       req_mon,
  cfsrch_rsp_if                       rsp_mon,
  output int                          pending,
  output int                          errors,
  output int                          checked
);
  import cfsrch_pkg::*;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [WordW-1:0]   data_out;
    logic [OffsW-1:0]   offs;
    logic [CntW-1:0]    cnt;
    logic [CntW-1:0]    fill;
    logic               empty;
    logic               full;
  } fifo_result_t;

  // Shadow copy of the ring and its pointers
  logic [WordW-1:0] ring [DEPTH];
  int unsigned      head_slot;
  int unsigned      tail_slot;
  int unsigned      held;
  logic [CapW-1:0]  capacity;

  fifo_result_t     expected_q[$];
  int               fail_count = 0;
  int               checked_n  = 0;

  // Clamp the register to 1..DEPTH
  function automatic int unsigned usable_slots();
    int unsigned c;
    c = capacity;
    if (c == 0) c = 1;
    if (c > DEPTH) c = DEPTH;
    return c;
  endfunction

  // Wrap by compare against the capacity, no modulo
  function automatic int unsigned advance(int unsigned p);
    return (p + 1 >= usable_slots()) ? 0 : p + 1;
  endfunction

  function automatic fifo_result_t predict_op(logic [OpW-1:0] op, logic [WordW-1:0] word);
    fifo_result_t r;
    int unsigned  cap;
    int unsigned  p;
    bit           hit;
    cap      = usable_slots();
    r        = '0;
    r.status = ST_OK;
    case (op)
      OP_ENQ: begin
        if (held >= cap) begin
          r.status = ST_FULL;
        end else begin
          ring[tail_slot] = word;
          tail_slot       = advance(tail_slot);
          held++;
        end
      end
      OP_DEQ, OP_PEEK: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data_out = ring[head_slot];
          if (op == OP_DEQ) begin
            head_slot = advance(head_slot);
            held--;
          end
        end
      end
      OP_FIND: begin
        r.status = ST_NOTFOUND;
        p        = head_slot;
        hit      = 1'b0;
        for (int unsigned i = 0; i < held; i++) begin
          if (!hit && ring[p] == word) begin
            hit      = 1'b1;
            r.status = ST_OK;
            r.offs   = (i > 15) ? 4'd15 : OffsW'(i);
          end
          p = advance(p);
        end
      end
      OP_COUNT: begin
        p = head_slot;
        for (int unsigned i = 0; i < held; i++) begin
          if (ring[p] == word) r.cnt = r.cnt + 1'b1;
          p = advance(p);
        end
      end
      OP_CLEAR: begin
        head_slot = 0;
        tail_slot = 0;
        held      = 0;
      end
      default: begin
      end
    endcase
    r.fill  = CntW'(held);
    r.empty = (held == 0);
    r.full  = (held >= cap);
    return r;
  endfunction

  task automatic show_result(input string label, input fifo_result_t r);
    $display("  %s status=%0d data_out=%h offset=%0d count=%0d fill=%0d empty=%0b full=%0b",
             label, r.status, r.data_out, r.offs, r.cnt, r.fill, r.empty, r.full);
  endtask

  // Track the capacity, check each response, queue a prediction per request
  always @(posedge clk) begin : track
    fifo_result_t want;
    fifo_result_t got;
    if (rst) begin
      head_slot = 0;
      tail_slot = 0;
      held      = 0;
      capacity  = CAP_RESET;
      expected_q.delete();
    end else begin
      if (cfg_we) capacity = cfg_wdata;

      if (rsp_mon.valid && rsp_mon.ready) begin
        got.status   = rsp_mon.status;
        got.data_out = rsp_mon.data_out;
        got.offs     = rsp_mon.found_offset;
        got.cnt      = rsp_mon.match_count;
        got.fill     = rsp_mon.fill_level;
        got.empty    = rsp_mon.is_empty;
        got.full     = rsp_mon.is_full;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: response with no transaction outstanding", $realtime);
            show_result("actual  ", got);
          end
        end else begin
          want = expected_q.pop_front();
          checked_n++;
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: response mismatch", $realtime);
              show_result("expected", want);
              show_result("actual  ", got);
            end
          end
        end
      end

      if (req_mon.valid && req_mon.ready)
        expected_q.push_back(predict_op(req_mon.op, req_mon.data_in));
    end
    pending <= expected_q.size();
    errors  <= fail_count;
    checked <= checked_n;
  end

endmodule

[verif/tb_top.sv]
// Testbench top for circular_fifo_with_search_core: clock, reset, request and
// capacity stimulus, random response stalls and the final verdict.
// Depends on cfsrch_pkg, both channel interfaces, the core and cfsrch_checker.
`timescale 1ns / 100ps

module tb_top;
  import cfsrch_pkg::*;

  localparam int unsigned DEPTH       = 16;
  localparam int          PHASES      = 9;
  localparam int          PHASE_ITEMS = 136;
  localparam int          LONG_HOLD   = 300;
  localparam int          SETTLE      = 24;

  // Op codes the core must treat as no-ops
  localparam logic [OpW-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OpW-1:0] OP_SPARE7 = 3'd7;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_we;
  logic [CapW-1:0] cfg_wdata;

  cfsrch_req_if req_ch ();
  cfsrch_rsp_if rsp_ch ();

  int pending;
  int errors;
  int checked;

  bit idling        = 1'b1;
  bit long_hold_req = 1'b0;
  int op_sent[8];
  int cap_writes    = 0;

  logic [WordW-1:0] word_pool[6];
  logic [CapW-1:0]  phase_cap[PHASES]  = '{5'd0, 5'd16, 5'd31, 5'd2, 5'd7, 5'd16, 5'd1,
                                           5'd12, 5'd16};
  int               phase_fill[PHASES] = '{70, 55, 75, 50, 60, 85, 50, 65, 60};

  always #2 clk = ~clk;

  circular_fifo_with_search_core #(.DEPTH(DEPTH)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  cfsrch_checker #(.DEPTH(DEPTH)) i_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_mon   (req_ch),
    .rsp_mon   (rsp_ch),
    .pending   (pending),
    .errors    (errors),
    .checked   (checked)
  );

  // Offer one transaction, with an optional idle gap first; hold until accepted
  task automatic send_item(input logic [OpW-1:0] op_code, input logic [WordW-1:0] word);
    int gap;
    @(negedge clk);
    if (idling && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 19);
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.op      <= op_code;
    req_ch.data_in <= word;
    do @(posedge clk); while (!req_ch.ready);
    op_sent[op_code]++;
  endtask

  // Stop offering and wait until every response has come back
  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CapW-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cap_writes++;
  endtask

  // Response side: random stalls, one long hold-off on request
  initial begin : sink_stall
    int span;
    rsp_ch.ready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (idling && $urandom_range(0, 2) == 0) begin
        span = $urandom_range(1, 19);
        rsp_ch.ready <= 1'b0;
        repeat (span) @(negedge clk);
      end else begin
        span = $urandom_range(1, 40);
        rsp_ch.ready <= 1'b1;
        repeat (span) @(negedge clk);
      end
    end
  end

  initial begin : watchdog
    #3_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int               draw;
    logic [OpW-1:0]   op_pick;
    logic [WordW-1:0] word_pick;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    req_ch.valid   = 1'b0;
    req_ch.op      = OP_ENQ;
    req_ch.data_in = '0;
    word_pool      = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                       32'h1234_5678, 32'h0bad_cafe};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty ring: refusals, search misses and the spare op codes
    send_item(OP_DEQ, 32'h0000_0000);
    send_item(OP_PEEK, 32'h0000_0000);
    send_item(OP_FIND, 32'h7fff_ffff);
    send_item(OP_COUNT, 32'h8000_0000);
    send_item(OP_SPARE6, 32'hffff_ffff);
    send_item(OP_SPARE7, 32'h5555_aaaa);

    // Extreme words, duplicate hits, find miss, then clear
    send_item(OP_ENQ, 32'h8000_0000);
    send_item(OP_ENQ, 32'h7fff_ffff);
    send_item(OP_ENQ, 32'hffff_ffff);
    send_item(OP_ENQ, 32'h7fff_ffff);
    send_item(OP_PEEK, 32'h0000_0000);
    send_item(OP_FIND, 32'h7fff_ffff);
    send_item(OP_FIND, 32'h1234_5678);
    send_item(OP_COUNT, 32'h7fff_ffff);
    send_item(OP_DEQ, 32'h0000_0000);
    send_item(OP_CLEAR, 32'h0000_0000);

    // Single-entry ring
    drain();
    write_capacity(5'd1);
    send_item(OP_ENQ, 32'h0000_0000);
    send_item(OP_ENQ, 32'ha5a5_a5a5);
    send_item(OP_FIND, 32'h0000_0000);
    send_item(OP_DEQ, 32'h0000_0000);

    // Shrink the capacity while entries are held, no wrap in the held range
    drain();
    write_capacity(5'd16);
    send_item(OP_ENQ, 32'h0000_0011);
    send_item(OP_ENQ, 32'h0000_0022);
    send_item(OP_ENQ, 32'h0000_0033);
    drain();
    write_capacity(5'd4);
    send_item(OP_ENQ, 32'h0000_0044);
    send_item(OP_ENQ, 32'h0000_0055);
    send_item(OP_DEQ, 32'h0000_0000);
    send_item(OP_FIND, 32'h0000_0044);
    send_item(OP_CLEAR, 32'h0000_0000);

    // Random phases, each at its own capacity and fill bias; clear first
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      write_capacity(phase_cap[ph]);
      idling = (ph != PHASES - 1);
      if (ph == 2) long_hold_req = 1'b1;
      word_pool[4] = $urandom();
      word_pool[5] = $urandom();
      send_item(OP_CLEAR, $urandom());
      repeat (PHASE_ITEMS) begin
        draw = $urandom_range(0, 99);
        if (draw < 60)
          op_pick = ($urandom_range(0, 99) < phase_fill[ph]) ? OP_ENQ : OP_DEQ;
        else if (draw < 68)
          op_pick = OP_PEEK;
        else if (draw < 80)
          op_pick = OP_FIND;
        else if (draw < 93)
          op_pick = OP_COUNT;
        else if (draw < 94)
          op_pick = OP_CLEAR;
        else if (draw < 96)
          op_pick = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
        else
          op_pick = OP_ENQ;
        word_pick = ($urandom_range(0, 9) < 6) ? word_pool[$urandom_range(0, 5)] : $urandom();
        send_item(op_pick, word_pick);
      end
    end

    // Let the last responses settle
    drain();
    repeat (SETTLE) @(posedge clk);

    $display("Run: %0d transactions (enq %0d, deq %0d, peek %0d, find %0d, count %0d,",
             op_sent[OP_ENQ] + op_sent[OP_DEQ] + op_sent[OP_PEEK] + op_sent[OP_FIND]
             + op_sent[OP_COUNT] + op_sent[OP_CLEAR] + op_sent[OP_SPARE6]
             + op_sent[OP_SPARE7], op_sent[OP_ENQ], op_sent[OP_DEQ], op_sent[OP_PEEK],
             op_sent[OP_FIND], op_sent[OP_COUNT]);
    $display("  clear %0d, spare ops %0d), %0d responses checked, %0d capacity writes",
             op_sent[OP_CLEAR], op_sent[OP_SPARE6] + op_sent[OP_SPARE7], checked,
             cap_writes);
    if (errors == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

[filelist.f]
src/cfsrch_pkg.sv
src/cfsrch_req_if.sv
src/cfsrch_rsp_if.sv
src/circular_fifo_with_search_core.sv
verif/cfsrch_checker.sv
verif/tb_top.sv
